>>> hdl/bda_pkg.sv
// Shared types and constants of the binary to decimal ASCII converter.
// Used by bda_div10 and binary_to_decimal_ascii; depends on nothing.
`default_nettype none

package bda_pkg;

  localparam int NUM_W   = 32;                // width of the binary input value
  localparam int DIG_MAX = 10;                // most digits of a 32-bit value
  localparam int CNT_W   = 4;                 // holds 1 .. DIG_MAX
  localparam int PROD_W  = 2 * NUM_W;         // reciprocal product width
  localparam int QSHIFT  = 35;                // v / 10 == (v * RECIP10) >> QSHIFT
  localparam int QUOT_W  = PROD_W - QSHIFT;   // quotient bits kept
  localparam int ASCII_W = 6;
  localparam int DATA_W  = 16;                // out_tdata, padded to bytes

  localparam logic [NUM_W-1:0]   RECIP10    = 32'hCCCC_CCCD;
  localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'h30;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [3:0]       digit_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Commands from the sequencer to the divide-by-ten unit
  typedef struct packed {
    logic start;   // load a fresh value
    logic step;    // replace the value by its quotient
  } div_ctrl_t;

  // What the divide-by-ten unit shows for its current value
  typedef struct packed {
    logic   quot_zero;  // quotient is zero: this is the last digit
    digit_t rem;        // value mod 10
  } div_stat_t;

endpackage

`default_nettype wire

>>> hdl/binary_to_decimal_ascii.sv
// Top level: unsigned 32-bit value to decimal ASCII digits, MSB first.
// Depends on bda_pkg and bda_div10.
//
//  channel | ports                     | payload
//  --------+---------------------------+------------------------------------------
//  input   | in_tvalid/in_tready       | in_tdata[31:0] number
//  result  | out_tvalid/out_tready     | out_tdata[5:0] ascii_digit, [9:6] count,
//          | out_tlast                 | out_tlast is_last
//
//  While a value is converted in_tready stays low: first the reciprocal
//  divide-by-ten unit produces the digits, one digit per multiply, then the digit
//  buffer drains through the output register, one digit per cycle unless the output stalls.
//  Output stalls stretch the drain phase only. Reset (rst_n low, synchronous)
//  returns the sequencer to idle and empties the output register.
`default_nettype none

module binary_to_decimal_ascii (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] number
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [5:0] ascii_digit, [9:6] digit_count, [15:10] zero
  output logic             out_tlast   // is_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]          state_r, state_nxt;
  bda_pkg::cnt_t       wr_idx_r, wr_idx_nxt;
  bda_pkg::cnt_t       rd_idx_r, rd_idx_nxt;
  bda_pkg::cnt_t       total_r, total_nxt;
  bda_pkg::digit_t     digit_r [bda_pkg::DIG_MAX];
  logic                out_valid_r, out_valid_nxt;
  logic [bda_pkg::ASCII_W-1:0] out_ascii_r;
  bda_pkg::cnt_t       out_cnt_r;
  logic                out_last_r;
  logic                in_xact;
  logic                out_load;
  bda_pkg::div_ctrl_t  div_ctrl;
  bda_pkg::div_stat_t  div_stat;

  assign in_tready = (state_r == S_IDLE);
  assign in_xact   = in_tvalid && in_tready;
  // In the emit state the output register takes a new digit when empty or being drained
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  assign div_ctrl.start = in_xact;
  assign div_ctrl.step  = (state_r == S_DIV);

  bda_div10 u_div10 (
    .clk  (clk),
    .din  (in_tdata),
    .ctrl (div_ctrl),
    .stat (div_stat)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_xact) begin
          wr_idx_nxt = '0;
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        wr_idx_nxt = wr_idx_r + 1'b1;
        if (div_stat.quot_zero) begin
          total_nxt  = wr_idx_r + 1'b1;
          rd_idx_nxt = wr_idx_r;
          state_nxt  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          rd_idx_nxt    = rd_idx_r - 1'b1;
          if (rd_idx_r == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Indexes, count and digit buffer (LSB digit at index 0)
  always_ff @(posedge clk) begin
    wr_idx_r <= wr_idx_nxt;
    rd_idx_r <= rd_idx_nxt;
    total_r  <= total_nxt;
    if (state_r == S_DIV) begin
      digit_r[wr_idx_r] <= div_stat.rem;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ascii_r <= bda_pkg::ASCII_ZERO + {2'b00, digit_r[rd_idx_r]};
      out_cnt_r   <= total_r;
      out_last_r  <= (rd_idx_r == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bda_pkg::DATA_W - bda_pkg::ASCII_W - bda_pkg::CNT_W){1'b0}},
                       out_cnt_r, out_ascii_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> hdl/bda_div10.sv
// Iterative divide-by-ten unit: one registered reciprocal multiply per step.
// Depends on bda_pkg.
`default_nettype none

module bda_div10 (
  input  wire logic               clk,
  input  wire bda_pkg::num_t      din,
  input  wire bda_pkg::div_ctrl_t ctrl,
  output bda_pkg::div_stat_t      stat
);

  bda_pkg::num_t                    cur_r;
  bda_pkg::num_t                    cur_nxt;
  logic [bda_pkg::PROD_W-1:0]       prod_r;
  logic [bda_pkg::PROD_W-1:0]       prod_nxt;
  logic [bda_pkg::QUOT_W-1:0]       quot;
  bda_pkg::num_t                    quot_x10;
  bda_pkg::num_t                    rem_full;

  // Quotient of the current value, straight from the registered product
  assign quot     = prod_r[bda_pkg::PROD_W-1:bda_pkg::QSHIFT];
  assign quot_x10 = (bda_pkg::NUM_W'(quot) << 3) + (bda_pkg::NUM_W'(quot) << 1);
  assign rem_full = cur_r - quot_x10;

  assign stat.rem       = rem_full[3:0];
  assign stat.quot_zero = (quot == '0);

  // Next value to hold and multiply
  always_comb begin
    cur_nxt = cur_r;
    if (ctrl.start) begin
      cur_nxt = din;
    end else if (ctrl.step) begin
      cur_nxt = bda_pkg::NUM_W'(quot);
    end
  end

  assign prod_nxt = {{bda_pkg::NUM_W{1'b0}}, cur_nxt} *
                    {{bda_pkg::NUM_W{1'b0}}, bda_pkg::RECIP10};

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/bda_checker.sv
// Port-level checker for binary_to_decimal_ascii, attached by bind.
// Sees only the top-level ports; depends on nothing else.
`default_nettype none

module bda_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Every result is a decimal digit character
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:0] >= 6'd48 && out_tdata[5:0] <= 6'd57)
    else $error("result is not a decimal digit");

  // Digit count stays in 1 .. 10, padding bits are zero
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:6] >= 4'd1 && out_tdata[9:6] <= 4'd10
                   && out_tdata[15:10] == 6'd0)
    else $error("digit count out of range");

  // Busy right after an input transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while converting");

  // A zero character in a single-digit result is flagged last
  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5:0] == 6'd48 && out_tdata[9:6] == 4'd1 |-> out_tlast)
    else $error("single-digit run not flagged last");

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
